FILE: hdl/rrts_pkg.sv
package rrts_pkg;

	localparam int ID_W = 8;
	localparam int TIME_W = 16;
	localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd10;

	typedef enum logic {
		KIND_ADD   = 1'b0,
		KIND_SERVE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] burst_time;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] burst;
	} ring_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   served_id;
		logic [TIME_W-1:0] remaining_time;
		logic              finished;
		status_t           status;
	} result_t;

endpackage

FILE: hdl/rrts_if.sv
interface rrts_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  task_id;
	logic [15:0] burst_time;

	modport source (output valid, output kind, output task_id, output burst_time,
		input ready);
	modport sink (input valid, input kind, input task_id, input burst_time,
		output ready);
endinterface

interface rrts_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  served_id;
	logic [15:0] remaining_time;
	logic        finished;
	logic [1:0]  status;

	modport source (output valid, output served_id, output remaining_time,
		output finished, output status, input ready);
	modport sink (input valid, input served_id, input remaining_time,
		input finished, input status, output ready);
endinterface

FILE: hdl/rrts_ring.sv
module rrts_ring import rrts_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  ring_entry_t              wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output ring_entry_t              head
);

	ring_entry_t mem [DEPTH];
	ring_entry_t head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// head always tracks the entry at the next front pointer
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			head_q <= wr_data;
		end else begin
			head_q <= mem[rd_addr];
		end
	end

	assign head = head_q;

endmodule

FILE: hdl/rrts_engine.sv
module rrts_engine import rrts_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  item_t                        item,
	input  logic [TIME_W-1:0]            quantum,
	input  ring_entry_t                  head,
	output result_t                      res,
	output logic                         wr_en,
	output logic [$clog2(MAX_TASKS)-1:0] wr_addr,
	output ring_entry_t                  wr_data,
	output logic [$clog2(MAX_TASKS)-1:0] rd_addr
);

	localparam int PTR_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_TASKS - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TASKS);

	logic [PTR_W-1:0]  front_q, front_nxt;
	logic [PTR_W-1:0]  back_q, back_nxt;
	logic [CNT_W-1:0]  count_q, count_nxt;
	logic [TIME_W:0]   diff;
	logic [TIME_W-1:0] t_new;
	logic [PTR_W-1:0]  front_inc, back_inc;

	assign diff = {1'b0, head.burst} - {1'b0, quantum};
	assign t_new = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign back_inc = (back_q == LAST_SLOT) ? '0 : back_q + 1'b1;

	always_comb begin
		front_nxt = front_q;
		back_nxt = back_q;
		count_nxt = count_q;
		wr_en = 1'b0;
		wr_addr = back_q;
		wr_data = '{task_id: item.task_id, burst: item.burst_time};
		res = '{served_id: '0, remaining_time: '0, finished: 1'b0, status: STATUS_OK};
		if (go) begin
			case (item.kind)
				KIND_ADD: begin
					res.served_id = item.task_id;
					res.remaining_time = item.burst_time;
					if (count_q == FULL_COUNT) begin
						res.status = STATUS_FULL;
					end else begin
						wr_en = 1'b1;
						back_nxt = back_inc;
						count_nxt = count_q + 1'b1;
					end
				end
				KIND_SERVE: begin
					if (count_q == '0) begin
						res.status = STATUS_EMPTY;
					end else begin
						res.served_id = head.task_id;
						res.remaining_time = t_new;
						front_nxt = front_inc;
						if (t_new == '0) begin
							res.finished = 1'b1;
							count_nxt = count_q - 1'b1;
						end else begin
							wr_en = 1'b1;
							wr_data = '{task_id: head.task_id, burst: t_new};
							back_nxt = back_inc;
						end
					end
				end
				default: begin
					res.status = STATUS_OK;
				end
			endcase
		end
	end

	assign rd_addr = front_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q <= '0;
			count_q <= '0;
		end else begin
			front_q <= front_nxt;
			back_q <= back_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

FILE: hdl/round_robin_time_slice_scheduler_unit.sv
// channel     dir  handshake     payload
// sched_in    in   valid/ready   kind, task_id, burst_time
// sched_out   out  valid/ready   served_id, remaining_time, finished, status
// cfg         in   cfg_we        cfg_wdata (quantum)
//
// one transaction per cycle unless the output stalls; result registered in res_q
// the ring read-modify-write with pointer update sets that rate
// reset clears pointers, task count and valid flags and loads quantum with 10
// ring contents are not cleared; only occupied slots are ever read
// a held result stalls the input stage; input is taken whenever that stage moves
module round_robin_time_slice_scheduler_unit import rrts_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	rrts_in_if.sink           sched_in,
	rrts_out_if.source        sched_out
);

	localparam int PTR_W = $clog2(MAX_TASKS);

	logic [TIME_W-1:0] quantum_q;
	logic              valid_s1;
	item_t             item_s1;
	logic              res_valid_q;
	result_t           res_q;
	logic              proceed;
	logic              go;
	result_t           res;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	ring_entry_t       wr_data;
	logic [PTR_W-1:0]  rd_addr;
	ring_entry_t       head;

	assign proceed = !res_valid_q || sched_out.ready;
	assign go = valid_s1 && proceed;
	assign sched_in.ready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sched_in.ready) begin
				valid_s1 <= sched_in.valid;
			end
			if (proceed) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sched_in.valid && sched_in.ready) begin
			item_s1 <= '{kind: kind_t'(sched_in.kind), task_id: sched_in.task_id,
				burst_time: sched_in.burst_time};
		end
		if (go) begin
			res_q <= res;
		end
	end

	rrts_engine #(
		.MAX_TASKS (MAX_TASKS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.item    (item_s1),
		.quantum (quantum_q),
		.head    (head),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr)
	);

	rrts_ring #(
		.DEPTH (MAX_TASKS)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.head    (head)
	);

	assign sched_out.valid = res_valid_q;
	assign sched_out.served_id = res_q.served_id;
	assign sched_out.remaining_time = res_q.remaining_time;
	assign sched_out.finished = res_q.finished;
	assign sched_out.status = res_q.status;

endmodule

FILE: sim/round_robin_time_slice_scheduler_unit_test.sv
`timescale 1ns / 100ps

module round_robin_time_slice_scheduler_unit_test;
	import rrts_pkg::*;

	localparam int SLOTS = 16;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_LIMIT = 1000;
	localparam int MAX_REPORTS = 50;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [TIME_W-1:0] cfg_wdata;

	rrts_in_if  in_if();
	rrts_out_if out_if();

	round_robin_time_slice_scheduler_unit #(
		.MAX_TASKS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sched_in(in_if),
		.sched_out(out_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scheduler state as the testbench sees it
	logic [ID_W-1:0]   ring_id [SLOTS];
	logic [TIME_W-1:0] ring_time [SLOTS];
	int unsigned       front_slot = 0;
	int unsigned       back_slot = 0;
	int unsigned       task_total = 0;
	logic [TIME_W-1:0] quantum_now = QUANTUM_RESET;

	result_t expected_results [$];

	int error_count = 0;
	int results_checked = 0;
	int requests_sent = 0;
	int finished_seen = 0;
	int full_seen = 0;
	int empty_seen = 0;
	int quantum_writes = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what);
		if (error_count < MAX_REPORTS)
			$display("mismatch on result %0d: %s", results_checked, what);
		error_count++;
	endtask

	function automatic void predict_schedule(input kind_t k, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] burst);
		result_t           r;
		logic [TIME_W-1:0] left;
		r = '0;
		r.status = STATUS_OK;
		if (k == KIND_ADD) begin
			r.served_id = id;
			r.remaining_time = burst;
			if (task_total >= SLOTS) begin
				r.status = STATUS_FULL;
				full_seen++;
			end else begin
				ring_id[back_slot] = id;
				ring_time[back_slot] = burst;
				back_slot = (back_slot + 1) % SLOTS;
				task_total++;
			end
		end else if (task_total == 0) begin
			r.status = STATUS_EMPTY;
			empty_seen++;
		end else begin
			left = (ring_time[front_slot] >= quantum_now) ?
				ring_time[front_slot] - quantum_now : '0;
			r.served_id = ring_id[front_slot];
			r.remaining_time = left;
			front_slot = (front_slot + 1) % SLOTS;
			task_total--;
			if (left == '0) begin
				r.finished = 1'b1;
				finished_seen++;
			end else begin
				// unfinished task goes to the back of the ring
				ring_id[back_slot] = r.served_id;
				ring_time[back_slot] = left;
				back_slot = (back_slot + 1) % SLOTS;
				task_total++;
			end
		end
		expected_results.push_back(r);
	endfunction

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing expected");
		end else begin
			want = expected_results.pop_front();
			if (out_if.served_id !== want.served_id)
				report_mismatch($sformatf("served_id got %0h want %0h",
					out_if.served_id, want.served_id));
			if (out_if.remaining_time !== want.remaining_time)
				report_mismatch($sformatf("remaining_time got %0h want %0h",
					out_if.remaining_time, want.remaining_time));
			if (out_if.finished !== want.finished)
				report_mismatch($sformatf("finished got %b want %b",
					out_if.finished, want.finished));
			if (out_if.status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d",
					out_if.status, want.status));
		end
		results_checked++;
	endtask

	// result side: check each transaction, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			check_result();
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			out_if.ready <= 1'b0;
			hold_left--;
		end else begin
			out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_request(input kind_t k, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] burst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.kind <= k;
		in_if.task_id <= id;
		in_if.burst_time <= burst;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		predict_schedule(k, id, burst);
		requests_sent++;
	endtask

	task automatic wait_results_drained();
		in_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [TIME_W-1:0] q);
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
		quantum_now = q;
		quantum_writes++;
	endtask

	task automatic test_serve_empty();
		send_request(KIND_SERVE, 8'hFF, 16'hFFFF);
	endtask

	// reset quantum, extreme ids and bursts, zero burst finishing on first turn
	task automatic test_default_quantum();
		send_request(KIND_ADD, 8'hFF, 16'hFFFF);
		send_request(KIND_ADD, 8'h00, 16'h0000);
		send_request(KIND_ADD, 8'h5A, 16'd25);
		repeat (4) send_request(KIND_SERVE, 8'h00, 16'h0000);
	endtask

	task automatic test_quantum_extremes();
		wait_results_drained();
		write_quantum(16'd0);
		send_request(KIND_SERVE, 8'h00, 16'h0000);
		wait_results_drained();
		write_quantum(16'd1);
		send_request(KIND_SERVE, 8'h00, 16'h0000);
		wait_results_drained();
		write_quantum(16'hFFFF);
		repeat (3) send_request(KIND_SERVE, 8'h00, 16'h0000);
	endtask

	// receiver holds off while adds keep coming: pipeline backs up, table overflows
	task automatic test_stall_fills_table();
		wait_results_drained();
		write_quantum(16'd10);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 150;
		repeat (SLOTS + 8)
			send_request(KIND_ADD, ID_W'($urandom_range(0, 255)),
				TIME_W'($urandom_range(0, 100)));
	endtask

	task automatic test_random_traffic(input int count, input int s_idle, input int r_idle,
		input logic [TIME_W-1:0] q);
		int    burst_hi;
		int    serve_pct;
		int    pick;
		kind_t k;
		logic [TIME_W-1:0] burst;
		wait_results_drained();
		write_quantum(q);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int n = 0; n < count; n++) begin
			// sender pauses halfway through the phase until every result is back
			if (n == count / 2)
				wait_results_drained();
			serve_pct = (task_total >= 12) ? 65 : (task_total <= 3) ? 35 : 50;
			k = ($urandom_range(0, 99) < serve_pct) ? KIND_SERVE : KIND_ADD;
			burst_hi = quantum_now * 4 + 1;
			if (burst_hi > 65535)
				burst_hi = 65535;
			pick = $urandom_range(0, 15);
			if (pick == 0)
				burst = TIME_W'($urandom);
			else if (pick == 1)
				burst = '0;
			else
				burst = TIME_W'($urandom_range(1, burst_hi));
			send_request(k, ID_W'($urandom_range(0, 255)), burst);
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.kind = KIND_ADD;
		in_if.task_id = '0;
		in_if.burst_time = '0;
		out_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_serve_empty();
		test_default_quantum();
		test_quantum_extremes();
		test_stall_fills_table();
		test_random_traffic(500, 21, 51, 16'd10);
		test_random_traffic(500, 51, 21, TIME_W'($urandom_range(1000, 65535)));
		test_random_traffic(500, 0, 0, TIME_W'($urandom_range(20, 200)));

		in_if.valid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		while (expected_results.size() != 0) begin
			void'(expected_results.pop_front());
			report_mismatch("expected result never arrived");
		end

		$display("%0d requests, %0d results checked, %0d quantum writes",
			requests_sent, results_checked, quantum_writes);
		$display("%0d tasks finished, %0d adds on full table, %0d serves on empty ring",
			finished_seen, full_seen, empty_seen);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
